@@ rtl/rmv_pkg.sv @@
// Package for the running mean, variance and CV block.
// Holds controller states, command and status bundles and result codes.
// No dependencies.
`default_nettype none

package rmv_pkg;

	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 192;
	localparam int M_TUSER_W = 2;
	localparam int ITER_W    = 7;

	typedef logic [1:0] res_status_t;
	localparam res_status_t RES_OK        = 2'd0;
	localparam res_status_t RES_FULL      = 2'd1;
	localparam res_status_t RES_MEAN_ZERO = 2'd2;

	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_STEP_GO,
		S_STEP_WAIT,
		S_MUL_GO,
		S_MUL_WAIT,
		S_STATS,
		S_VAR_WAIT,
		S_SQRT_WAIT,
		S_CV_CHK,
		S_CV_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic step_go;
		logic mean_upd;
		logic mul_go;
		logic m2_add;
		logic stats;
		logic var_go;
		logic sqrt_go;
		logic cv_chk;
		logic cv_div_go;
		logic cv_take;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic full;
		logic count_zero;
		logic mean_zero;
		logic div_done;
		logic mul_done;
		logic sqrt_done;
		logic cv_over;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/rmv_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Uses nothing from the package beyond the iteration count width.
`default_nettype none

module rmv_div #(
	parameter int DVW = 53,
	parameter int DW  = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [rmv_pkg::ITER_W-1:0] iters,
	input  wire [DW-1:0]              dividend,
	input  wire [DVW-1:0]             rem_init,
	input  wire [DVW-1:0]             divisor,
	output logic [DW-1:0]             quot,
	output logic                      done
);

	logic [DW-1:0]              d_q;
	logic [DVW-1:0]             rem_q;
	logic [DVW-1:0]             div_q;
	logic [rmv_pkg::ITER_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [DVW:0]               trial;
	logic [DVW:0]               diff;
	logic                       qbit;

	always_comb begin
		trial = {rem_q, d_q[DW-1]};
		diff  = trial - {1'b0, div_q};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters - 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= dividend;
			rem_q <= rem_init;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVW-1:0] : trial[DVW-1:0];
			d_q   <= {d_q[DW-2:0], qbit};
		end
	end

	assign quot = d_q;
	assign done = done_q;

	// the partial remainder stays below the divisor while iterating
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < div_q))
		else $error("divider remainder reached the divisor");

endmodule

`default_nettype wire

@@ rtl/rmv_dp.sv @@
// Datapath: statistics registers, serial multiplier, serial square root,
// shared divider and result registers. Depends on rmv_pkg and rmv_div.
`default_nettype none

module rmv_dp #(
	parameter int COUNT_BITS = 32,
	parameter int FRAC_BITS  = 53
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  rmv_pkg::cmd_t         cmd,
	output rmv_pkg::sts_t         sts,
	input  wire                   in_action,
	input  wire [63:0]            in_sample,
	output logic [7:0]            out_noise,
	output logic [31:0]           out_count,
	output logic [52:0]           out_mean,
	output logic [63:0]           out_m2,
	output logic [31:0]           out_cv,
	output rmv_pkg::res_status_t  out_status
);

	localparam int CB  = COUNT_BITS;
	localparam int F   = FRAC_BITS;
	localparam int DVW = (CB > F) ? CB : F;
	localparam int K   = F + 4;
	localparam int SH  = 2 * F - 40;
	localparam int SHR = (SH > 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;

	logic                 action_q;
	logic [F-1:0]         x_q;
	logic [7:0]           noise_q;
	logic [CB-1:0]        count_q;
	logic [F-1:0]         mean_q;
	logic [63:0]          m2_q;
	logic                 up_q;
	logic [F-1:0]         a_q;
	logic [31:0]          cv_q;
	rmv_pkg::res_status_t status_q;

	// multiplier
	logic [F-1:0]         mhi_q, mlo_q;
	logic [5:0]           mcnt_q;
	logic                 mbusy_q, mdone_q;
	logic [F:0]           msum;
	// square root
	logic [63:0]          sval_q;
	logic [32:0]          srem_q;
	logic [31:0]          sroot_q;
	logic [4:0]           scnt_q;
	logic                 sbusy_q, sdone_q;
	logic [34:0]          sr, strial, sdiff;
	// divider hook-up
	logic                       div_start;
	logic [rmv_pkg::ITER_W-1:0] div_iters;
	logic [63:0]                div_dividend;
	logic [DVW-1:0]             div_rem_init, div_divisor;
	logic [63:0]                quot;
	logic                       div_done;

	logic [F-1:0]   b_val;
	logic [127:0]   prod_w, shifted;
	logic [63:0]    m2_inc;
	logic [64:0]    m2_sum;
	logic [127:0]   cv_num;
	logic           cv_over;
	logic [63:0]    count_w, mean_w;

	function automatic logic [rmv_pkg::ITER_W-1:0] ITER_W_F();
		return rmv_pkg::ITER_W'(F);
	endfunction

	always_comb begin
		b_val   = up_q ? (x_q - mean_q) : (mean_q - x_q);
		msum    = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, a_q} : '0);
		prod_w  = 128'({mhi_q, mlo_q});
		shifted = (prod_w >> SHR) << SHL;
		m2_inc  = (|shifted[127:64]) ? '1 : shifted[63:0];
		m2_sum  = {1'b0, m2_q} + {1'b0, m2_inc};
		sr      = {srem_q, sval_q[63:62]};
		strial  = {1'b0, sroot_q, 2'b01};
		sdiff   = sr - strial;
		cv_num  = 128'(sroot_q) << K;
		cv_over = (cv_num[127:32] >= 96'(mean_q));
	end

	always_comb begin
		div_start    = cmd.step_go | cmd.var_go | cmd.cv_div_go;
		div_iters    = ITER_W_F();
		div_dividend = 64'(a_q) << (64 - F);
		div_rem_init = '0;
		div_divisor  = DVW'(count_q);
		if (cmd.var_go) begin
			div_iters    = 7'd64;
			div_dividend = m2_q;
		end else if (cmd.cv_div_go) begin
			div_iters    = 7'd32;
			div_dividend = {cv_num[31:0], 32'd0};
			div_rem_init = cv_num[32 +: DVW];
			div_divisor  = DVW'(mean_q);
		end
	end

	rmv_div #(.DVW(DVW), .DW(64)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.iters    (div_iters),
		.dividend (div_dividend),
		.rem_init (div_rem_init),
		.divisor  (div_divisor),
		.quot     (quot),
		.done     (div_done)
	);

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			m2_q    <= '0;
		end else begin
			if (cmd.eval && action_q == rmv_pkg::ACT_RESTART) begin
				count_q <= '0;
				m2_q    <= '0;
			end else if (cmd.eval && !sts.full) begin
				count_q <= count_q + 1'b1;
				if (count_q == '0)
					mean_q <= x_q;
			end
			if (cmd.mean_upd)
				mean_q <= up_q ? (mean_q + quot[F-1:0]) : (mean_q - quot[F-1:0]);
			if (cmd.m2_add)
				m2_q <= m2_sum[64] ? '1 : m2_sum[63:0];
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			x_q      <= in_sample[63 -: F];
			noise_q  <= (in_action == rmv_pkg::ACT_RESTART) ? 8'd0 : in_sample[7:0];
			status_q <= rmv_pkg::RES_OK;
			cv_q     <= '0;
		end
		if (cmd.eval) begin
			up_q <= (x_q >= mean_q);
			a_q  <= (x_q >= mean_q) ? (x_q - mean_q) : (mean_q - x_q);
			if (action_q == rmv_pkg::ACT_SAMPLE && sts.full)
				status_q <= rmv_pkg::RES_FULL;
		end
		if (cmd.stats && count_q != '0 && mean_q == '0 && status_q == rmv_pkg::RES_OK)
			status_q <= rmv_pkg::RES_MEAN_ZERO;
		if (cmd.cv_chk && cv_over)
			cv_q <= '1;
		if (cmd.cv_take)
			cv_q <= quot[31:0];
	end

	// serial shift-add multiplier, one multiplier bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (cmd.mul_go) begin
			mbusy_q <= 1'b1;
			mdone_q <= 1'b0;
			mcnt_q  <= 6'(F - 1);
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q - 1'b1;
			if (mcnt_q == '0) begin
				mbusy_q <= 1'b0;
				mdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			mhi_q <= '0;
			mlo_q <= b_val;
		end else if (mbusy_q) begin
			mhi_q <= msum[F:1];
			mlo_q <= {msum[0], mlo_q[F-1:1]};
		end
	end

	// digit-by-digit square root, two radicand bits a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
			scnt_q  <= '0;
		end else if (cmd.sqrt_go) begin
			sbusy_q <= 1'b1;
			sdone_q <= 1'b0;
			scnt_q  <= '1;
		end else if (sbusy_q) begin
			scnt_q <= scnt_q - 1'b1;
			if (scnt_q == '0) begin
				sbusy_q <= 1'b0;
				sdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_go) begin
			sval_q  <= quot;
			srem_q  <= '0;
			sroot_q <= '0;
		end else if (sbusy_q) begin
			sval_q <= {sval_q[61:0], 2'b00};
			if (sr >= strial) begin
				srem_q  <= sdiff[32:0];
				sroot_q <= {sroot_q[30:0], 1'b1};
			end else begin
				srem_q  <= sr[32:0];
				sroot_q <= {sroot_q[30:0], 1'b0};
			end
		end
	end

	// result registers, loaded when the result is handed over
	always_comb begin
		count_w = 64'(count_q);
		mean_w  = 64'(mean_q) << (53 - F);
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_noise  <= noise_q;
			out_count  <= count_w[31:0];
			out_mean   <= mean_w[52:0];
			out_m2     <= m2_q;
			out_cv     <= cv_q;
			out_status <= status_q;
		end
	end

	always_comb begin
		sts.restart    = (action_q == rmv_pkg::ACT_RESTART);
		sts.full       = (count_q == '1);
		sts.count_zero = (count_q == '0);
		sts.mean_zero  = (mean_q == '0);
		sts.div_done   = div_done;
		sts.mul_done   = mdone_q;
		sts.sqrt_done  = sdone_q;
		sts.cv_over    = cv_over;
	end

endmodule

`default_nettype wire

@@ rtl/rmv_ctrl.sv @@
// Controller state machine: sequences each item through the datapath and
// owns both handshakes. Depends on rmv_pkg.
`default_nettype none

module rmv_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	input  rmv_pkg::sts_t  sts,
	output rmv_pkg::cmd_t  cmd
);

	rmv_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmv_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rmv_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = rmv_pkg::S_EVAL;
				end
			end
			rmv_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.restart || sts.full || sts.count_zero)
					state_d = rmv_pkg::S_STATS;
				else
					state_d = rmv_pkg::S_STEP_GO;
			end
			rmv_pkg::S_STEP_GO: begin
				cmd.step_go = 1'b1;
				state_d     = rmv_pkg::S_STEP_WAIT;
			end
			rmv_pkg::S_STEP_WAIT: begin
				if (sts.div_done) begin
					cmd.mean_upd = 1'b1;
					state_d      = rmv_pkg::S_MUL_GO;
				end
			end
			rmv_pkg::S_MUL_GO: begin
				cmd.mul_go = 1'b1;
				state_d    = rmv_pkg::S_MUL_WAIT;
			end
			rmv_pkg::S_MUL_WAIT: begin
				if (sts.mul_done) begin
					cmd.m2_add = 1'b1;
					state_d    = rmv_pkg::S_STATS;
				end
			end
			rmv_pkg::S_STATS: begin
				cmd.stats = 1'b1;
				if (sts.count_zero || sts.mean_zero) begin
					state_d = rmv_pkg::S_FINISH;
				end else begin
					cmd.var_go = 1'b1;
					state_d    = rmv_pkg::S_VAR_WAIT;
				end
			end
			rmv_pkg::S_VAR_WAIT: begin
				if (sts.div_done) begin
					cmd.sqrt_go = 1'b1;
					state_d     = rmv_pkg::S_SQRT_WAIT;
				end
			end
			rmv_pkg::S_SQRT_WAIT: begin
				if (sts.sqrt_done)
					state_d = rmv_pkg::S_CV_CHK;
			end
			rmv_pkg::S_CV_CHK: begin
				cmd.cv_chk = 1'b1;
				if (sts.cv_over) begin
					state_d = rmv_pkg::S_FINISH;
				end else begin
					cmd.cv_div_go = 1'b1;
					state_d       = rmv_pkg::S_CV_WAIT;
				end
			end
			rmv_pkg::S_CV_WAIT: begin
				if (sts.div_done) begin
					cmd.cv_take = 1'b1;
					state_d     = rmv_pkg::S_FINISH;
				end
			end
			rmv_pkg::S_FINISH: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = rmv_pkg::S_IDLE;
				end
			end
			default: state_d = rmv_pkg::S_IDLE;
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result emitted over an untaken result");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

`default_nettype wire

@@ rtl/running_mean_variance_cv.sv @@
// Top level of the running mean, variance and coefficient-of-variation block.
// Depends on rmv_pkg, rmv_ctrl, rmv_dp (and rmv_div through rmv_dp).
//
//  channel  | dir | tdata                                  | tuser
//  ---------+-----+----------------------------------------+-------------
//  s_axis   | in  | sample[63:0]                           | action[0]
//  m_axis   | out | noise, count, mean, m2, cv, zero pad   | status[1:0]
//
// The work on an item uses the shared serial divider (step, variance, CV
// quotient, one bit a cycle), the serial multiplier and the two-bit-a-cycle
// square root. A first sample skips the step and multiply, a later sample
// that leaves the mean at zero skips the variance, root and CV, and a
// restart skips them all.
// Reset clears the count, mean and M2 and idles the controller.
// One item is in work at a time; a finished result waits in the output
// register while the next transfer on s_axis is taken, and a stalled m_axis
// only holds the block once the next result is ready to leave.
`default_nettype none

module running_mean_variance_cv #(
	parameter int COUNT_BITS = 32,
	parameter int FRAC_BITS  = 53
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire  [rmv_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // sample[63:0]
	input  wire  [rmv_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // action[0]
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// noise_byte[7:0], count[39:8], mean[92:40], m2[156:93], cv[188:157]
	output logic [rmv_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic [rmv_pkg::M_TUSER_W-1:0]   m_axis_tuser   // status[1:0]
);

	rmv_pkg::cmd_t        cmd;
	rmv_pkg::sts_t        sts;
	logic [7:0]           noise;
	logic [31:0]          count;
	logic [52:0]          mean;
	logic [63:0]          m2;
	logic [31:0]          cv;
	rmv_pkg::res_status_t status;

	// sequence each item and handle both transfers
	rmv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the statistics and do the arithmetic
	rmv_dp #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (s_axis_tuser[0]),
		.in_sample  (s_axis_tdata),
		.out_noise  (noise),
		.out_count  (count),
		.out_mean   (mean),
		.out_m2     (m2),
		.out_cv     (cv),
		.out_status (status)
	);

	// pack the result, lowest field first, pad to whole bytes
	assign m_axis_tdata = {3'b000, cv, m2, mean, count, noise};
	assign m_axis_tuser = status;

endmodule

`default_nettype wire
